>>> rtl/eplt_pkg.sv
// Package with constants, types and register indexes of the encoder PLL tracker.
`timescale 1ns / 1ps
package eplt_pkg;
    localparam int ANGLE_BITS    = 14;
    localparam int TABLE_BITS    = 7;
    localparam int TABLE_ENTRIES = 128;
    localparam int FRAC_BITS     = ANGLE_BITS - TABLE_BITS;
    localparam int SEED_SAMPLES  = 20;
    localparam int POS_BITS      = ANGLE_BITS + 16;
    localparam int VEL_BITS      = 48;
    localparam int ADDR_BITS     = 6;
    localparam int DATA_BITS     = 64;

    typedef logic [ANGLE_BITS-1:0] t_angle;

    typedef enum logic [2:0] {
        REG_REVERSE_DIR    = 3'd0,
        REG_ZERO_OFFSET    = 3'd1,
        REG_POLE_PAIRS     = 3'd2,
        REG_PERIOD_STEP    = 3'd3,
        REG_KP_STEP        = 3'd4,
        REG_KI_STEP        = 3'd5,
        REG_SNAP_THRESHOLD = 3'd6
    } t_reg_index;

    localparam logic CMD_TABLE_WRITE = 1'b1;
endpackage

>>> rtl/encoder_pll_tracker_core.sv
// Encoder PLL tracker: offset linearization, multi-turn count, electrical count and tracking PLL.
// A sample item runs through the sequencer states in order; seeding samples leave after S_ELEC.
// One item at a time: o_stall is high until the sequencer is back in S_IDLE, so a held
// result item also holds off the next item; a table write is taken in S_IDLE.
// The state sequence is set by the two reads of the offset table memory and by the six
// products that share one 25 x 25 multiplier.
// Reset (synchronous, active low) restores configuration registers and loop state; the table is not cleared.
`timescale 1ns / 1ps
module encoder_pll_tracker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_command,
    input  logic [13:0]                    i_raw_angle,
    input  logic [6:0]                     i_table_index,
    input  logic signed [13:0]             i_table_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_ready_res,
    output logic [13:0]                    o_angle_count,
    output logic signed [31:0]             o_turn_count,
    output logic [29:0]                    o_pll_position,
    output logic signed [47:0]             o_velocity,
    output logic [19:0]                    o_electrical_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [eplt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [eplt_pkg::DATA_BITS-1:0] pwdata,
    output logic [eplt_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import eplt_pkg::*;

    // Sequencer states. Each state drives at most one product into the shared multiplier;
    // the product is registered and consumed by the following state.
    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_MUL_I, S_CNT, S_MUL_E, S_ELEC,
        S_PRED_L, S_POS1, S_ERR, S_MUL_KP, S_MUL_KI, S_VEL, S_DONE
    } t_state;

    // Configuration registers.
    logic        r_reverse_dir;
    logic [13:0] r_zero_offset;
    logic [6:0]  r_pole_pairs;
    logic [23:0] r_period_step;
    logic [23:0] r_kp_step;
    logic [23:0] r_ki_step;
    logic [46:0] r_snap_threshold;

    t_reg_index w_reg_idx;
    assign w_reg_idx = t_reg_index'(paddr[5:3]);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse_dir    <= 1'b0;
            r_zero_offset    <= 14'd0;
            r_pole_pairs     <= 7'd1;
            r_period_step    <= 24'd839;
            r_kp_step        <= 24'd1054000;
            r_ki_step        <= 24'd1293600;
            r_snap_threshold <= 47'd646800;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                REG_REVERSE_DIR:    r_reverse_dir    <= pwdata[0];
                REG_ZERO_OFFSET:    r_zero_offset    <= pwdata[13:0];
                REG_POLE_PAIRS:     r_pole_pairs     <= pwdata[6:0];
                REG_PERIOD_STEP:    r_period_step    <= pwdata[23:0];
                REG_KP_STEP:        r_kp_step        <= pwdata[23:0];
                REG_KI_STEP:        r_ki_step        <= pwdata[23:0];
                REG_SNAP_THRESHOLD: r_snap_threshold <= pwdata[46:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_REVERSE_DIR:    prdata = {63'd0, r_reverse_dir};
            REG_ZERO_OFFSET:    prdata = {50'd0, r_zero_offset};
            REG_POLE_PAIRS:     prdata = {57'd0, r_pole_pairs};
            REG_PERIOD_STEP:    prdata = {40'd0, r_period_step};
            REG_KP_STEP:        prdata = {40'd0, r_kp_step};
            REG_KI_STEP:        prdata = {40'd0, r_ki_step};
            REG_SNAP_THRESHOLD: prdata = {17'd0, r_snap_threshold};
            default:            prdata = '0;
        endcase
    end

    // Sequencer and loop state.
    t_state                 r_state;
    t_angle                 r_raw;
    logic signed [13:0]     r_o1;
    t_angle                 r_cnt;
    logic [19:0]            r_elec;
    logic [4:0]             r_seed;
    t_angle                 r_prev;
    logic [POS_BITS-1:0]    r_pos;
    logic signed [VEL_BITS-1:0] r_vel;
    logic [31:0]            r_turn;
    logic signed [14:0]     r_err;
    logic [29:0]            r_ph;
    logic signed [49:0]     r_prod;

    // Offset table memory: one write port and one registered read port.
    logic [13:0]            mem [TABLE_ENTRIES];
    logic [TABLE_BITS-1:0]  w_rd_addr;
    logic [13:0]            r_rd_data;
    logic                   w_in_accept;

    assign o_stall     = (r_state != S_IDLE);
    assign w_in_accept = i_valid && (r_state == S_IDLE);

    always_comb begin
        if (r_state == S_RD1) begin
            w_rd_addr = r_raw[ANGLE_BITS-1:FRAC_BITS] + TABLE_BITS'(1);
        end else begin
            w_rd_addr = r_raw[ANGLE_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && i_command == CMD_TABLE_WRITE) begin
            mem[i_table_index] <= i_table_value;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // Shared multiplier operand selection.
    logic signed [24:0] w_ma, w_mb;
    logic signed [14:0] w_odiff;

    assign w_odiff = 15'(signed'(r_rd_data)) - 15'(r_o1);

    always_comb begin
        case (r_state)
            S_MUL_I: begin
                w_ma = 25'(w_odiff);
                w_mb = {18'd0, r_raw[FRAC_BITS-1:0]};
            end
            S_MUL_E: begin
                w_ma = {11'd0, r_cnt};
                w_mb = {18'd0, r_pole_pairs};
            end
            S_ELEC: begin
                w_ma = 25'(signed'(r_vel[47:24]));
                w_mb = {1'b0, r_period_step};
            end
            S_PRED_L: begin
                w_ma = {1'b0, r_vel[23:0]};
                w_mb = {1'b0, r_period_step};
            end
            S_MUL_KP: begin
                w_ma = 25'(r_err);
                w_mb = {1'b0, r_kp_step};
            end
            S_MUL_KI: begin
                w_ma = 25'(r_err);
                w_mb = {1'b0, r_ki_step};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Datapath terms used by individual states.
    logic signed [15:0] w_interp;
    logic [15:0]        w_cnt_full;
    logic signed [15:0] w_turn_d, w_turn_w;
    logic signed [15:0] w_err_d, w_err_w;
    logic signed [48:0] w_vel_sum;
    logic signed [47:0] w_vel_sat;
    logic [47:0]        w_vel_mag;

    always_comb begin
        // The product of offset slope and fraction is floored by the arithmetic shift.
        w_interp   = 16'(r_o1) + r_prod[22:7];
        w_cnt_full = {2'd0, r_raw} - w_interp - {2'd0, r_zero_offset};

        // Turn delta folded into half a turn either way.
        w_turn_d = {2'd0, r_cnt} - {2'd0, r_prev};
        if (w_turn_d > 16'sd8192) begin
            w_turn_w = w_turn_d - 16'sd16384;
        end else if (w_turn_d < -16'sd8192) begin
            w_turn_w = w_turn_d + 16'sd16384;
        end else begin
            w_turn_w = w_turn_d;
        end

        // Phase error against the integer part of the predicted position.
        w_err_d = {2'd0, r_cnt} - {2'd0, r_pos[POS_BITS-1:16]};
        if (w_err_d > 16'sd8192) begin
            w_err_w = w_err_d - 16'sd16384;
        end else if (w_err_d < -16'sd8192) begin
            w_err_w = w_err_d + 16'sd16384;
        end else begin
            w_err_w = w_err_d;
        end

        // Velocity integration saturates to 48 bits, then snaps small speeds to zero.
        w_vel_sum = 49'(r_vel) + 49'(signed'(r_prod[38:0]));
        if (w_vel_sum > 49'sh0_7FFF_FFFF_FFFF) begin
            w_vel_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (w_vel_sum < -49'sh0_8000_0000_0000) begin
            w_vel_sat = 48'sh8000_0000_0000;
        end else begin
            w_vel_sat = w_vel_sum[47:0];
        end
        w_vel_mag = w_vel_sat[47] ? (48'd0 - w_vel_sat) : w_vel_sat;
    end

    logic r_ready_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seed       <= 5'(SEED_SAMPLES);
            r_prev       <= '0;
            r_pos        <= '0;
            r_vel        <= '0;
            r_turn       <= '0;
            r_ready_flag <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_prod <= w_ma * w_mb;
            // In S_DONE the result register is either reloaded or still held.
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept && i_command != CMD_TABLE_WRITE) begin
                        r_raw   <= r_reverse_dir ? ~i_raw_angle : i_raw_angle;
                        r_state <= S_RD0;
                    end
                end
                S_RD0:    r_state <= S_RD1;
                S_RD1: begin
                    r_o1    <= r_rd_data;
                    r_state <= S_MUL_I;
                end
                S_MUL_I:  r_state <= S_CNT;
                S_CNT: begin
                    r_cnt   <= w_cnt_full[13:0];
                    r_state <= S_MUL_E;
                end
                S_MUL_E:  r_state <= S_ELEC;
                S_ELEC: begin
                    r_elec <= r_prod[19:0];
                    if (r_seed != 5'd0) begin
                        // Seeding sample: load the previous angle and report not ready.
                        r_seed       <= r_seed - 5'd1;
                        r_prev       <= r_cnt;
                        r_ready_flag <= 1'b0;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_PRED_L;
                    end
                end
                S_PRED_L: begin
                    r_ph    <= r_prod[29:0];
                    r_state <= S_POS1;
                end
                S_POS1: begin
                    // Prediction: high partial product plus the top of the low one.
                    r_pos   <= r_pos + r_ph + {6'd0, r_prod[47:24]};
                    r_turn  <= r_turn + 32'(w_turn_w);
                    r_prev  <= r_cnt;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= w_err_w[14:0];
                    r_state <= S_MUL_KP;
                end
                S_MUL_KP: r_state <= S_MUL_KI;
                S_MUL_KI: begin
                    r_pos   <= r_pos + r_prod[37:8];
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    r_vel        <= (w_vel_mag < {1'b0, r_snap_threshold}) ? '0 : w_vel_sat;
                    r_ready_flag <= 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // Wait here only while the previous result item is still held.
                    if (!o_valid || !i_stall) begin
                        o_valid            <= 1'b1;
                        o_ready_res        <= r_ready_flag;
                        o_angle_count      <= r_cnt;
                        o_electrical_count <= r_elec;
                        o_turn_count       <= r_ready_flag ? r_turn : '0;
                        o_pll_position     <= r_ready_flag ? r_pos : '0;
                        o_velocity         <= r_ready_flag ? r_vel : '0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the encoder PLL tracker core.
`timescale 1ns / 1ps
module tb_top;
    import eplt_pkg::*;

    // Every result of a sample item, as the block reports it.
    typedef struct {
        bit        ready;
        bit [13:0] angle;
        bit [31:0] turns;
        bit [29:0] position;
        bit [47:0] velocity;
        bit [19:0] electrical;
    } t_tracker_result;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 20;
    localparam longint VEL_TOP     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VEL_BOTTOM  = -VEL_TOP - 1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_command;
    logic [13:0]        i_raw_angle;
    logic [6:0]         i_table_index;
    logic signed [13:0] i_table_value;
    logic               o_valid;
    logic               i_stall;
    logic               o_ready_res;
    logic [13:0]        o_angle_count;
    logic signed [31:0] o_turn_count;
    logic [29:0]        o_pll_position;
    logic signed [47:0] o_velocity;
    logic [19:0]        o_electrical_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic               pready;

    encoder_pll_tracker_core u_top (.*);

    // Predicted copy of the block: offset table, loop state and registers.
    bit signed [13:0] offset_mem [TABLE_ENTRIES];
    int               seeds_left;
    bit [13:0]        last_angle;
    bit [29:0]        track_pos;
    longint           track_vel;
    bit [31:0]        turn_total;
    bit               mirror_en;
    bit [13:0]        zero_cnt;
    bit [6:0]         pole_cnt;
    bit [23:0]        period_q24;
    bit [23:0]        kp_q24;
    bit [23:0]        ki_q16;
    bit [46:0]        snap_level;

    t_tracker_result pending_results[$];
    int              error_count;
    int              sender_idle_pct;
    int              receiver_idle_pct;
    int              quiet_cycles;
    bit [13:0]       sweep_angle;

    // The free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Wraps an angle difference into half a turn either way.
    function automatic longint wrap_half_turn(longint d);
        if (d > 8192) begin
            return d - 16384;
        end else if (d < -8192) begin
            return d + 16384;
        end
        return d;
    endfunction

    // Velocity times sample period, split in two partial products and floored.
    function automatic longint scale_by_period(longint v, bit [23:0] p);
        bit [63:0] mag;
        bit [63:0] hi_part;
        bit [63:0] lo_part;
        mag     = (v < 0) ? 64'(-v) : 64'(v);
        hi_part = mag * p[23:12];
        lo_part = mag * p[11:0];
        if (v >= 0) begin
            return longint'((hi_part + (lo_part >> 12)) >> 12);
        end
        return -longint'((hi_part + ((lo_part + 4095) >> 12) + 4095) >> 12);
    endfunction

    // Works out the result of one sample item and advances the predicted state.
    function automatic t_tracker_result track_sample(bit [13:0] raw);
        t_tracker_result res;
        bit [13:0] angle_in;
        bit [6:0]  slot;
        bit [6:0]  next_slot;
        longint    off_a;
        longint    off_b;
        longint    interp;
        longint    corrected;
        longint    err;
        longint    mag;
        angle_in  = mirror_en ? ~raw : raw;
        slot      = angle_in[13:7];
        next_slot = slot + 7'd1;
        off_a     = offset_mem[slot];
        off_b     = offset_mem[next_slot];
        interp    = off_a + (((off_b - off_a) * longint'(angle_in[6:0])) >>> 7);
        corrected = longint'(angle_in) - interp - longint'(zero_cnt);
        res = '{default: '0};
        res.angle      = corrected[13:0];
        res.electrical = 20'(32'(res.angle) * 32'(pole_cnt));
        if (seeds_left > 0) begin
            seeds_left--;
            last_angle = res.angle;
            return res;
        end
        turn_total += 32'(wrap_half_turn(longint'(res.angle) - longint'(last_angle)));
        last_angle = res.angle;
        track_pos  = track_pos + 30'(scale_by_period(track_vel, period_q24));
        err        = wrap_half_turn(longint'(res.angle) - longint'(track_pos[29:16]));
        track_pos  = track_pos + 30'((err * longint'(kp_q24)) >>> 8);
        track_vel += err * longint'(ki_q16);
        if (track_vel > VEL_TOP) begin
            track_vel = VEL_TOP;
        end else if (track_vel < VEL_BOTTOM) begin
            track_vel = VEL_BOTTOM;
        end
        mag = (track_vel < 0) ? -track_vel : track_vel;
        if (mag < longint'(snap_level)) begin
            track_vel = 0;
        end
        res.ready    = 1'b1;
        res.turns    = turn_total;
        res.position = track_pos;
        res.velocity = track_vel[47:0];
        return res;
    endfunction

    // Sends one item, sometimes after a random idle gap, and predicts its result or its table write.
    task automatic send_item(bit cmd, bit [13:0] raw, bit [6:0] index, bit [13:0] value);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_raw_angle   <= raw;
        i_table_index <= index;
        i_table_value <= value;
        do @(posedge i_clk); while (o_stall);
        if (cmd == CMD_TABLE_WRITE) begin
            offset_mem[index] = value;
        end else begin
            pending_results.push_back(track_sample(raw));
        end
    endtask

    task automatic send_sample(bit [13:0] raw);
        send_item(~CMD_TABLE_WRITE, raw, 7'($urandom), 14'($urandom));
    endtask

    task automatic send_table_write(bit [6:0] index, bit [13:0] value);
        send_item(CMD_TABLE_WRITE, 14'($urandom), index, value);
    endtask

    // Lowers valid and waits until every predicted result has come back. A table
    // write yields no result, so a further drain wait lets it land.
    task automatic drain_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write over the configuration port: setup, then access.
    task automatic write_register(t_reg_index reg_id, bit [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_id, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_id)
            REG_REVERSE_DIR:    mirror_en  = value[0];
            REG_ZERO_OFFSET:    zero_cnt   = value[13:0];
            REG_POLE_PAIRS:     pole_cnt   = value[6:0];
            REG_PERIOD_STEP:    period_q24 = value[23:0];
            REG_KP_STEP:        kp_q24     = value[23:0];
            REG_KI_STEP:        ki_q16     = value[23:0];
            REG_SNAP_THRESHOLD: snap_level = value[46:0];
            default: ;
        endcase
    endtask

    task automatic write_all_registers(bit rev, bit [13:0] zero, bit [6:0] poles,
                                       bit [23:0] per, bit [23:0] kp, bit [23:0] ki,
                                       bit [46:0] snap);
        write_register(REG_REVERSE_DIR, 64'(rev));
        write_register(REG_ZERO_OFFSET, 64'(zero));
        write_register(REG_POLE_PAIRS, 64'(poles));
        write_register(REG_PERIOD_STEP, 64'(per));
        write_register(REG_KP_STEP, 64'(kp));
        write_register(REG_KI_STEP, 64'(ki));
        write_register(REG_SNAP_THRESHOLD, 64'(snap));
    endtask

    // Every table entry gets a value before any sample can read it, the extreme
    // offsets and both ends of the index range among them.
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i == 0) begin
                send_table_write(7'(i), 14'sh2000);
            end else if (i == TABLE_ENTRIES - 1) begin
                send_table_write(7'(i), 14'sh1FFF);
            end else begin
                send_table_write(7'(i), 14'($urandom_range(200)) - 14'd100);
            end
        end
    endtask

    // The seeding samples after reset, with the angle extremes, then the first
    // tracking samples, including a jump right across the wrap point.
    task automatic test_seeding_and_extremes();
        send_sample(14'd0);
        send_sample(14'h3FFF);
        send_sample(14'h2AAA);
        send_sample(14'h1555);
        for (int i = 0; i < SEED_SAMPLES - 4; i++) begin
            send_sample(14'(i * 97));
        end
        send_sample(14'h3FFF);
        send_sample(14'd0);
        send_sample(14'd8191);
        send_sample(14'd8192);
    endtask

    // Register extremes while tracking a steady sweep: mirrored direction, largest
    // zero offset, pole pairs that overflow the electrical count, full-scale gains,
    // and the two ends of the snap threshold.
    task automatic test_register_extremes();
        drain_block();
        write_all_registers(1'b1, 14'h3FFF, 7'd127, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 47'd0);
        repeat (12) begin
            sweep_angle += 14'd700;
            send_sample(sweep_angle);
        end
        drain_block();
        write_all_registers(1'b0, 14'd0, 7'd0, 24'd0, 24'd0, 24'hFFFFFF,
                            47'h7FFF_FFFF_FFFF);
        repeat (8) begin
            sweep_angle -= 14'd300;
            send_sample(sweep_angle);
        end
        drain_block();
        write_all_registers(1'b0, 14'd1234, 7'd64, 24'd839, 24'd1054000, 24'd1293600,
                            47'd646800);
        repeat (12) begin
            sweep_angle += 14'd40;
            send_sample(sweep_angle);
        end
    endtask

    // Mostly smooth motion with a random speed, so the loop locks and the turn count
    // climbs or falls across the wrap point, mixed with jumps and table rewrites.
    task automatic test_random_motion(int items, int send_pct, int recv_pct);
        int speed;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        speed = $urandom_range(1200) - 600;
        for (int n = 0; n < items; n++) begin
            if (n == items / 2) begin
                // The sender holds off until the block has handed back everything.
                drain_block();
            end
            if ($urandom_range(99) < 5) begin
                send_table_write(7'($urandom), 14'($urandom));
            end else if ($urandom_range(99) < 8) begin
                sweep_angle = 14'($urandom);
                send_sample(sweep_angle);
            end else begin
                if ($urandom_range(99) < 4) begin
                    speed = $urandom_range(1200) - 600;
                end
                sweep_angle = sweep_angle + 14'(speed + $urandom_range(6) - 3);
                send_sample(sweep_angle);
            end
        end
    endtask

    task automatic load_random_registers();
        drain_block();
        write_all_registers(1'($urandom), 14'($urandom), 7'($urandom_range(64, 1)),
                            24'($urandom_range(2000)), 24'($urandom_range(4000000)),
                            24'($urandom_range(3000000)), 47'($urandom_range(2000000)));
    endtask

    // Receiver stall, redrawn every cycle.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Each accepted result is compared field by field with the oldest prediction.
    always @(posedge i_clk) begin
        t_tracker_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual angle %0d",
                         $realtime, o_angle_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_ready_res !== want.ready) begin
                    $display("%0t: ready expected %0d actual %0d",
                             $realtime, want.ready, o_ready_res);
                    error_count++;
                end
                if (o_angle_count !== want.angle) begin
                    $display("%0t: angle expected %0d actual %0d",
                             $realtime, want.angle, o_angle_count);
                    error_count++;
                end
                if (o_turn_count !== want.turns) begin
                    $display("%0t: turns expected %0d actual %0d",
                             $realtime, $signed(want.turns), o_turn_count);
                    error_count++;
                end
                if (o_pll_position !== want.position) begin
                    $display("%0t: position expected %h actual %h",
                             $realtime, want.position, o_pll_position);
                    error_count++;
                end
                if (o_velocity !== want.velocity) begin
                    $display("%0t: velocity expected %h actual %h",
                             $realtime, want.velocity, o_velocity);
                    error_count++;
                end
                if (o_electrical_count !== want.electrical) begin
                    $display("%0t: electrical expected %0d actual %0d",
                             $realtime, want.electrical, o_electrical_count);
                    error_count++;
                end
            end
        end
    end

    // Ends a run in which nothing has moved on the input, the output or the register port for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_command         = 1'b0;
        i_raw_angle       = '0;
        i_table_index     = '0;
        i_table_value     = '0;
        i_stall           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        error_count       = 0;
        quiet_cycles      = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        sweep_angle       = '0;
        // Predicted state after reset.
        seeds_left = SEED_SAMPLES;
        last_angle = '0;
        track_pos  = '0;
        track_vel  = 0;
        turn_total = '0;
        mirror_en  = 1'b0;
        zero_cnt   = '0;
        pole_cnt   = 7'd1;
        period_q24 = 24'd839;
        kp_q24     = 24'd1054000;
        ki_q16     = 24'd1293600;
        snap_level = 47'd646800;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        sender_idle_pct   = 37;
        receiver_idle_pct = 87;
        test_table_fill();
        test_seeding_and_extremes();
        test_register_extremes();
        load_random_registers();
        test_random_motion(105, 37, 87);
        load_random_registers();
        test_random_motion(105, 87, 37);
        load_random_registers();
        test_random_motion(105, 0, 0);
        drain_block();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/eplt_pkg.sv
rtl/encoder_pll_tracker_core.sv
dv/tb_top.sv
